/* design/ddtus_pkg.sv */
`default_nettype none

package ddtus_pkg;

  localparam int PIX_W     = 11;
  localparam int TILE_W    = 8;
  localparam int BUD_W     = 16;
  localparam int ROT_W     = 3;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 3;
  localparam int IN_DW     = 48;
  localparam int OUT_DW    = 40;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  localparam logic [ROT_W-1:0] ROT_0 = 3'd0;
  localparam logic [ROT_W-1:0] ROT_1 = 3'd1;
  localparam logic [ROT_W-1:0] ROT_2 = 3'd2;
  localparam logic [ROT_W-1:0] ROT_3 = 3'd3;

  localparam logic [REG_IDX_W-1:0] REG_FIRST_BUDGET  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FOLLOW_BUDGET = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROTATION_MODE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_UI_ENABLED    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UI_ACTIVE     = 3'd6;

  localparam logic OP_RENDER = 1'b0;
  localparam logic OP_NOTIFY = 1'b1;

  localparam logic [BUD_W-1:0] RST_FIRST_BUDGET  = 16'hffff;
  localparam logic [BUD_W-1:0] RST_FOLLOW_BUDGET = 16'hffff;
  localparam logic [ROT_W-1:0] RST_ROTATION_MODE = 3'd0;
  localparam logic [PIX_W-1:0] RST_SCREEN_WIDTH  = 11'd128;
  localparam logic [PIX_W-1:0] RST_SCREEN_HEIGHT = 11'd64;
  localparam logic             RST_UI_ENABLED    = 1'b0;
  localparam logic             RST_UI_ACTIVE     = 1'b1;

  typedef struct packed {
    logic [TILE_W-1:0] x0;
    logic [TILE_W-1:0] y0;
    logic [TILE_W-1:0] x1;
    logic [TILE_W-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic [BUD_W-1:0] first_budget;
    logic [BUD_W-1:0] follow_budget;
    logic [ROT_W-1:0] rotation_mode;
    logic [PIX_W-1:0] screen_width;
    logic [PIX_W-1:0] screen_height;
    logic             ui_enabled;
    logic             ui_active;
  } cfg_t;

  typedef struct packed {
    logic  opcode;
    logic  force_req;
    logic  nonempty;
    rect_t tiles;
  } item_t;

  typedef struct packed {
    logic              update_valid;
    logic [TILE_W-1:0] tile_x;
    logic [TILE_W-1:0] tile_y;
    logic [TILE_W-1:0] tile_cols;
    logic [TILE_W-1:0] tile_rows;
    logic              took_new_area;
    logic              still_updating;
  } res_t;

  function automatic logic has_area(rect_t r);
    return (r.x1 > r.x0) && (r.y1 > r.y0);
  endfunction

endpackage

`default_nettype wire

/* design/ddtus_cfg.sv */
`default_nettype none

module ddtus_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [ddtus_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [ddtus_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [ddtus_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                              cfg_pready,
  output ddtus_pkg::cfg_t                   cfg
);

  ddtus_pkg::cfg_t cfg_r;
  ddtus_pkg::cfg_t cfg_nxt;
  logic [ddtus_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx        = cfg_paddr[ddtus_pkg::CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        ddtus_pkg::REG_FIRST_BUDGET:  cfg_nxt.first_budget  = cfg_pwdata[ddtus_pkg::BUD_W-1:0];
        ddtus_pkg::REG_FOLLOW_BUDGET: cfg_nxt.follow_budget = cfg_pwdata[ddtus_pkg::BUD_W-1:0];
        ddtus_pkg::REG_ROTATION_MODE: cfg_nxt.rotation_mode = cfg_pwdata[ddtus_pkg::ROT_W-1:0];
        ddtus_pkg::REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_pwdata[ddtus_pkg::PIX_W-1:0];
        ddtus_pkg::REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_pwdata[ddtus_pkg::PIX_W-1:0];
        ddtus_pkg::REG_UI_ENABLED:    cfg_nxt.ui_enabled    = cfg_pwdata[0];
        ddtus_pkg::REG_UI_ACTIVE:     cfg_nxt.ui_active     = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ddtus_pkg::REG_FIRST_BUDGET:  cfg_prdata = {16'b0, cfg_r.first_budget};
      ddtus_pkg::REG_FOLLOW_BUDGET: cfg_prdata = {16'b0, cfg_r.follow_budget};
      ddtus_pkg::REG_ROTATION_MODE: cfg_prdata = {29'b0, cfg_r.rotation_mode};
      ddtus_pkg::REG_SCREEN_WIDTH:  cfg_prdata = {21'b0, cfg_r.screen_width};
      ddtus_pkg::REG_SCREEN_HEIGHT: cfg_prdata = {21'b0, cfg_r.screen_height};
      ddtus_pkg::REG_UI_ENABLED:    cfg_prdata = {31'b0, cfg_r.ui_enabled};
      ddtus_pkg::REG_UI_ACTIVE:     cfg_prdata = {31'b0, cfg_r.ui_active};
      default:                      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_budget  <= ddtus_pkg::RST_FIRST_BUDGET;
      cfg_r.follow_budget <= ddtus_pkg::RST_FOLLOW_BUDGET;
      cfg_r.rotation_mode <= ddtus_pkg::RST_ROTATION_MODE;
      cfg_r.screen_width  <= ddtus_pkg::RST_SCREEN_WIDTH;
      cfg_r.screen_height <= ddtus_pkg::RST_SCREEN_HEIGHT;
      cfg_r.ui_enabled    <= ddtus_pkg::RST_UI_ENABLED;
      cfg_r.ui_active     <= ddtus_pkg::RST_UI_ACTIVE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/ddtus_front.sv */
`default_nettype none

module ddtus_front (
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [ddtus_pkg::IN_DW-1:0] in_tdata,
  input  wire logic                        in_tuser,
  input  wire ddtus_pkg::cfg_t             cfg,
  input  wire logic                        q_full,
  output logic                             q_push,
  output ddtus_pkg::item_t                 q_item
);

  logic [ddtus_pkg::PIX_W-1:0] l, t, r, b, w, h;
  logic [ddtus_pkg::PIX_W-1:0] r7, b7, h_b, h_t7, w_r, w_l7, l_w, r_w7;
  ddtus_pkg::rect_t tiles;

  assign l = in_tdata[11:1];
  assign t = in_tdata[22:12];
  assign r = in_tdata[33:23];
  assign b = in_tdata[44:34];
  assign w = cfg.screen_width;
  assign h = cfg.screen_height;

  assign r7   = r + 11'd7;
  assign b7   = b + 11'd7;
  assign h_b  = h - b;
  assign h_t7 = h - t + 11'd7;
  assign w_r  = w - r;
  assign w_l7 = w - l + 11'd7;
  assign l_w  = w - l;
  assign r_w7 = w - r + 11'd7;

  always_comb begin
    case (cfg.rotation_mode)
      ddtus_pkg::ROT_0: tiles = '{x0: l[10:3],    y0: t[10:3],
                                  x1: r7[10:3],   y1: b7[10:3]};
      ddtus_pkg::ROT_1: tiles = '{x0: h_b[10:3],  y0: l[10:3],
                                  x1: h_t7[10:3], y1: r7[10:3]};
      ddtus_pkg::ROT_2: tiles = '{x0: w_r[10:3],  y0: h_b[10:3],
                                  x1: w_l7[10:3], y1: h_t7[10:3]};
      ddtus_pkg::ROT_3: tiles = '{x0: t[10:3],    y0: l_w[10:3],
                                  x1: b7[10:3],   y1: r_w7[10:3]};
      default:          tiles = '{x0: '0,         y0: '0,
                                  x1: w[10:3],    y1: h[10:3]};
    endcase
  end

  assign in_tready        = !q_full;
  assign q_push           = in_tvalid && !q_full;
  assign q_item.opcode    = in_tuser;
  assign q_item.force_req = in_tdata[0];
  assign q_item.nonempty  = (r > l) && (b > t);
  assign q_item.tiles     = tiles;

endmodule

`default_nettype wire

/* design/ddtus_fifo.sv */
`default_nettype none

module ddtus_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ddtus_pkg::item_t push_item,
  input  wire logic             pop,
  output ddtus_pkg::item_t      pop_item,
  output logic                  full,
  output logic                  empty
);

  ddtus_pkg::item_t mem_r [ddtus_pkg::Q_DEPTH];
  logic [ddtus_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ddtus_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ddtus_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == ddtus_pkg::Q_CNT_W'(ddtus_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/ddtus_back.sv */
`default_nettype none

module ddtus_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ddtus_pkg::cfg_t  cfg,
  input  wire logic             q_empty,
  input  wire ddtus_pkg::item_t q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output ddtus_pkg::res_t       out_res
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_CMP  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_ADJ  = 7'b0010000,
    ST_POST = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  ddtus_pkg::rect_t pend_r, pend_nxt;
  ddtus_pkg::rect_t rem_r, rem_nxt;
  logic wanted_r, wanted_nxt;
  logic [ddtus_pkg::BUD_W-1:0] budget_r, budget_nxt;
  logic [ddtus_pkg::BUD_W-1:0] prod_r, prod_nxt;
  logic [ddtus_pkg::TILE_W-1:0] div_r, div_nxt;
  logic [ddtus_pkg::BUD_W-1:0] quo_r, quo_nxt;
  logic [ddtus_pkg::TILE_W-1:0] part_r, part_nxt;
  logic [ddtus_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  ddtus_pkg::res_t hold_r, hold_nxt;
  logic out_valid_r, out_valid_nxt;
  ddtus_pkg::res_t out_res_r, out_res_nxt;

  logic [ddtus_pkg::TILE_W-1:0] cw, ch, sum_x, rows;
  logic [ddtus_pkg::TILE_W:0] trial, diff;
  logic split;

  assign q_pop      = (state_r == ST_IDLE) && !q_empty;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  assign cw    = pend_r.x1 - pend_r.x0;
  assign ch    = pend_r.y1 - pend_r.y0;
  assign sum_x = pend_r.x0 + budget_r[ddtus_pkg::TILE_W-1:0];
  assign split = ({8'b0, cw} > budget_r) && !ddtus_pkg::has_area(rem_r);
  assign trial = {part_r, quo_r[ddtus_pkg::BUD_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign rows  = (div_r == '0) ? '0 : quo_r[ddtus_pkg::TILE_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    rem_nxt       = rem_r;
    wanted_nxt    = wanted_r;
    budget_nxt    = budget_r;
    prod_nxt      = prod_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    part_nxt      = part_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          hold_nxt  = '0;
          state_nxt = ST_FIN;
          if (q_item.opcode == ddtus_pkg::OP_NOTIFY) begin
            wanted_nxt = 1'b1;
          end else if (cfg.ui_enabled) begin
            if (!q_item.force_req && ddtus_pkg::has_area(pend_r)) begin
              budget_nxt = cfg.follow_budget;
              state_nxt  = ST_MUL;
            end else if (cfg.ui_active && (q_item.force_req || wanted_r)) begin
              wanted_nxt             = 1'b0;
              hold_nxt.took_new_area = 1'b1;
              if (q_item.nonempty) begin
                pend_nxt = q_item.tiles;
                if (cfg.first_budget != '0) begin
                  budget_nxt = cfg.first_budget;
                  state_nxt  = ST_MUL;
                end
              end
            end
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = {8'b0, cw} * {8'b0, ch};
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        hold_nxt.update_valid = 1'b1;
        hold_nxt.tile_x       = pend_r.x0;
        hold_nxt.tile_y       = pend_r.y0;
        if (budget_r >= prod_r) begin
          hold_nxt.tile_cols = cw;
          hold_nxt.tile_rows = ch;
          if (ddtus_pkg::has_area(rem_r)) begin
            pend_nxt = rem_r;
            rem_nxt  = '0;
          end else begin
            pend_nxt = '0;
          end
          state_nxt = ST_FIN;
        end else begin
          if (split) begin
            rem_nxt     = pend_r;
            rem_nxt.x0  = sum_x;
            pend_nxt.x1 = sum_x;
            div_nxt     = budget_r[ddtus_pkg::TILE_W-1:0];
          end else begin
            div_nxt = cw;
          end
          hold_nxt.tile_cols = div_nxt;
          quo_nxt   = budget_r;
          part_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!diff[ddtus_pkg::TILE_W]) begin
          part_nxt = diff[ddtus_pkg::TILE_W-1:0];
          quo_nxt  = {quo_r[ddtus_pkg::BUD_W-2:0], 1'b1};
        end else begin
          part_nxt = trial[ddtus_pkg::TILE_W-1:0];
          quo_nxt  = {quo_r[ddtus_pkg::BUD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ddtus_pkg::DIV_CNT_W'(ddtus_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_ADJ;
        end
      end
      ST_ADJ: begin
        hold_nxt.tile_rows = rows;
        pend_nxt.y0        = pend_r.y0 + rows;
        state_nxt          = ST_POST;
      end
      ST_POST: begin
        if (!ddtus_pkg::has_area(pend_r) && ddtus_pkg::has_area(rem_r)) begin
          pend_nxt = rem_r;
          rem_nxt  = '0;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_res_nxt                = hold_r;
          out_res_nxt.still_updating = ddtus_pkg::has_area(pend_r);
          out_valid_nxt              = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    budget_r  <= budget_nxt;
    prod_r    <= prod_nxt;
    div_r     <= div_nxt;
    quo_r     <= quo_nxt;
    part_r    <= part_nxt;
    cnt_r     <= cnt_nxt;
    hold_r    <= hold_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      rem_r       <= '0;
      wanted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      rem_r       <= rem_nxt;
      wanted_r    <= wanted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/display_dirty_tile_update_scheduler.sv */
// Dirty-tile update scheduler.
// Input stream: one transaction per request. in_tuser is the opcode (render
// request or rendering-needed notification); in_tdata carries force_req and
// the dirty pixel rectangle. Every input transaction yields exactly one
// result transaction on the out_ stream with the tile transfer, if any.
// The front converts the pixel rectangle to tiles for the configured
// rotation in the accept cycle and writes a two-entry queue; the back pops
// one item at a time, none until its result is registered. A notification
// or an item without a transfer goes straight to the finish state; a
// transfer within budget passes the multiply and compare states, and one
// over budget also the 16-step shift-subtract row-count divider and the
// adjust and post states. The user must write registers over the cfg_ APB
// port only while the block is idle; the block does not enforce this.
// Synchronous reset clears the queue, the pending and remainder areas and
// the render flag, and loads the register defaults.
// When the receiver stalls, the result holds in the output register, the
// back finishes its current item and waits, and the queue keeps accepting
// input until it is full.
`default_nettype none

module display_dirty_tile_update_scheduler (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [0] force_req, [11:1] pixel_left, [22:12] pixel_top,
  // [33:23] pixel_right, [44:34] pixel_bottom
  input  wire logic [ddtus_pkg::IN_DW-1:0]  in_tdata,
  // [0] opcode
  input  wire logic                         in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [0] update_valid, [8:1] tile_x, [16:9] tile_y, [24:17] tile_cols,
  // [32:25] tile_rows, [33] took_new_area, [34] still_updating
  output logic      [ddtus_pkg::OUT_DW-1:0] out_tdata,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [ddtus_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [ddtus_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [ddtus_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                              cfg_pready
);

  ddtus_pkg::cfg_t  cfg;
  ddtus_pkg::item_t push_item;
  ddtus_pkg::item_t pop_item;
  ddtus_pkg::res_t  res;
  logic q_push, q_pop, q_full, q_empty;

  ddtus_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ddtus_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  ddtus_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  ddtus_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {5'b0, res.still_updating, res.took_new_area, res.tile_rows,
                      res.tile_cols, res.tile_y, res.tile_x, res.update_valid};

endmodule

`default_nettype wire
